FILE: hdl/ciq_pkg.sv
// ciq_pkg.sv: shared types, codes and sizes of the collapsing issue queue
`timescale 1ns / 1ps

package ciq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_COUNT   = 64;

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_W  = $clog2(TAG_COUNT);

   localparam int PC_W   = 16;
   localparam int CLS_W  = 2;
   localparam int BUSY_W = 3;
   localparam int KIND_W = 3;
   localparam int SLOT_W = 4;
   localparam int OCC_W  = 5;
   localparam int SRC_N  = 3;

   // actions carried in the request tuser
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_WAKE   = 2'd1;
   localparam logic [1:0] ACT_ISSUE  = 2'd2;
   localparam logic [1:0] ACT_FLUSH  = 2'd3;

   // unit classes
   localparam logic [CLS_W-1:0] CLS_INT  = 2'd0;
   localparam logic [CLS_W-1:0] CLS_MUL  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_LOP  = 2'd2;
   localparam logic [CLS_W-1:0] CLS_LDST = 2'd3;

   // result kinds carried in the response tuser
   localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ISSUED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSHED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DONE     = 3'd5;

   typedef struct packed {
      logic [PC_W-1:0]             pc;
      logic [CLS_W-1:0]            cls;
      logic [TAG_W-1:0]            dest;
      logic [SRC_N-1:0][TAG_W-1:0] src_tag;
      logic [SRC_N-1:0]            src_rdy;
      logic                        mark;
   } entry_type;

   typedef struct packed {
      logic             shift;
      logic             wake;
      logic [TAG_W-1:0] wake_tag;
   } cell_ctl_type;

endpackage

FILE: hdl/ciq_cell.sv
// ciq_cell.sv: one queue slot, loads from its younger neighbor on a shift
`timescale 1ns / 1ps

module ciq_cell
   import ciq_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         wr_en,
   input  entry_type    wr_data,
   input  entry_type    nbr,
   output entry_type    ent
);

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      priority if (wr_en) begin
         ent_in = wr_data;
      end else if (ctl.shift) begin
         ent_in = nbr;
      end else if (ctl.wake) begin
         for (int s = 0; s < SRC_N; s++) begin
            if (ent_ff.src_tag[s] == ctl.wake_tag) begin
               ent_in.src_rdy[s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

FILE: hdl/collapsing_issue_queue.sv
// collapsing_issue_queue.sv: top level, control sequencer over a row of queue cells
//
//  channel | dir | handshake              | contents
//  req     | in  | req_tvalid/req_tready  | tuser action, tdata instruction and wakeup fields
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser kind, tdata pc/class/tag/slot/occupancy, tlast
//
//  insert and wakeup: accept, then ST_EXEC updates the cells and loads the output register
//  issue and flush rotate the n held entries through cell 0: the first pass picks entries; a second
//    pass, run only when something was picked, emits them and closes the gaps
//  reset clears the entry count, the sequencer and the response valid only; slot contents are not cleared
//  a stalled response holds the sequencer only where a word must be written out
`timescale 1ns / 1ps

module collapsing_issue_queue
   import ciq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // instr_pc, unit_class, dest_tag, src_a_tag, src_a_ready,
                                    // src_b_tag, src_b_ready, src_c_tag, src_c_ready,
                                    // unit_busy, wake_tag, zero pad
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_pc, out_class, out_dest_tag, slot, occupancy, zero pad
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last_item
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MARK,
      ST_EMIT,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic [1:0]       action;
      entry_type        ent;
      logic [TAG_W-1:0] wake_tag;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PC_W-1:0]   pc;
      logic [CLS_W-1:0]  cls;
      logic [TAG_W-1:0]  dest;
      logic [SLOT_W-1:0] slot;
      logic [OCC_W-1:0]  occ;
      logic              last;
   } word_type;

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic [3:0]        taken_ff, taken_in;
   logic              any_ff, any_in;
   logic              out_valid_ff, out_valid_in;
   word_type          out_ff, out_in;

   entry_type                 ents [QUEUE_DEPTH];
   cell_ctl_type              ctl;
   logic [QUEUE_DEPTH-1:0]    wr_en;
   logic                      wr_go;
   logic [IDX_W-1:0]          wr_idx;
   entry_type                 wr_data;
   entry_type                 head;
   entry_type                 req_ent;
   logic                      head_gone;
   logic                      out_free;
   logic                      emit;
   word_type                  word;
   logic                      accept;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;
   assign head     = ents[0];

   always_comb begin
      req_ent.pc         = req_tdata[15:0];
      req_ent.cls        = req_tdata[17:16];
      req_ent.dest       = req_tdata[23:18];
      req_ent.src_tag[0] = req_tdata[29:24];
      req_ent.src_rdy[0] = req_tdata[30];
      req_ent.src_tag[1] = req_tdata[36:31];
      req_ent.src_rdy[1] = req_tdata[37];
      req_ent.src_tag[2] = req_tdata[43:38];
      req_ent.src_rdy[2] = req_tdata[44];
      req_ent.mark       = 1'b0;
   end

   // class 3 is pinned taken so load/store entries never issue
   always_comb begin
      if (item_ff.action == ACT_ISSUE) begin
         head_gone = !taken_ff[head.cls] && (&head.src_rdy);
      end else begin
         head_gone = head.pc >= item_ff.ent.pc;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      keep_in      = keep_ff;
      taken_in     = taken_ff;
      any_in       = any_ff;
      ctl.shift    = 1'b0;
      ctl.wake     = 1'b0;
      ctl.wake_tag = item_ff.wake_tag;
      wr_go        = 1'b0;
      wr_idx       = IDX_W'(count_ff - CNT_W'(1));
      wr_data      = head;
      emit         = 1'b0;
      word         = '0;
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in.action   = req_tuser;
               item_in.ent      = req_ent;
               item_in.wake_tag = req_tdata[53:48];
               steps_in         = count_ff;
               keep_in          = '0;
               any_in           = 1'b0;
               taken_in         = {1'b1, req_tdata[47:45]};
               if (req_tuser == ACT_INSERT || req_tuser == ACT_WAKE) begin
                  state_in = ST_EXEC;
               end else if (count_ff == '0) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               emit      = 1'b1;
               word.last = 1'b1;
               word.occ  = OCC_W'(count_ff);
               if (item_ff.action == ACT_WAKE) begin
                  ctl.wake  = 1'b1;
                  word.kind = KIND_DONE;
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  word.kind = KIND_REJECTED;
               end else begin
                  wr_go     = 1'b1;
                  wr_idx    = IDX_W'(count_ff);
                  wr_data   = item_ff.ent;
                  count_in  = count_ff + CNT_W'(1);
                  word.kind = KIND_INSERTED;
                  word.slot = SLOT_W'(count_ff);
                  word.occ  = OCC_W'(count_ff + CNT_W'(1));
               end
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            // rotate: head goes back in at the tail carrying its verdict
            ctl.shift    = 1'b1;
            wr_go        = 1'b1;
            wr_data.mark = head_gone;
            keep_in      = keep_ff + {{(CNT_W-1){1'b0}}, !head_gone};
            any_in       = any_ff || head_gone;
            if (head_gone) begin
               taken_in = taken_ff | (4'b0001 << head.cls);
            end
            steps_in = steps_ff - CNT_W'(1);
            if (steps_ff == CNT_W'(1)) begin
               steps_in = count_ff;
               state_in = any_in ? ST_EMIT : ST_CLOSE;
            end
         end
         ST_EMIT: begin
            if (!head.mark || out_free) begin
               ctl.shift = 1'b1;
               if (head.mark) begin
                  emit      = 1'b1;
                  word.kind = (item_ff.action == ACT_ISSUE) ? KIND_ISSUED : KIND_FLUSHED;
                  word.pc   = head.pc;
                  word.cls  = head.cls;
                  word.dest = head.dest;
                  word.occ  = OCC_W'(keep_ff);
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  wr_go        = 1'b1;
                  wr_data.mark = 1'b0;
               end
               steps_in = steps_ff - CNT_W'(1);
               if (steps_ff == CNT_W'(1)) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               emit      = 1'b1;
               word.kind = any_ff ? KIND_DONE : KIND_NONE;
               word.occ  = OCC_W'(count_ff);
               word.last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = emit;
         out_in       = word;
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         wr_en[i] = wr_go && (wr_idx == IDX_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff  <= item_in;
      steps_ff <= steps_in;
      keep_ff  <= keep_in;
      taken_ff <= taken_in;
      any_ff   <= any_in;
      out_ff   <= out_in;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type nbr;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nbr = ents[i];
      end else begin : g_body
         assign nbr = ents[i+1];
      end
      ciq_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .wr_en   (wr_en[i]),
         .wr_data (wr_data),
         .nbr     (nbr),
         .ent     (ents[i])
      );
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {7'd0, out_ff.occ, out_ff.slot, out_ff.dest, out_ff.cls, out_ff.pc};

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (keep_ff <= count_ff))
      else $error("kept count above held entries during emit pass");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_ISSUED) |-> (out_ff.cls != CLS_LDST))
      else $error("load/store entry issued");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_INSERTED)
         |-> (out_ff.occ == ({1'b0, out_ff.slot} + OCC_W'(1))))
      else $error("inserted slot and occupancy disagree");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (steps_ff != '0 && count_ff != '0))
      else $error("pick pass running on an empty queue");

endmodule
